FILE: rtl/kmc_pkg.sv
`default_nettype none

package kmc_pkg;

  // Point and centroid formats
  localparam int COORD_BITS  = 9;
  localparam int FRAC_BITS   = 4;
  localparam int CENT_W      = COORD_BITS + FRAC_BITS;

  // Per-pass capacity and accumulator widths
  localparam int MAX_POINTS  = 1024;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int SUM_W       = COORD_BITS + $clog2(MAX_POINTS);
  localparam int DIVD_W      = SUM_W + FRAC_BITS;
  localparam int DIVC_W      = $clog2(DIVD_W + 1);

  // Squared distance: one term is below 2^(2*CENT_W), two terms add one bit
  localparam int SQ_W        = 2 * CENT_W;
  localparam int DIST_W      = SQ_W + 1;

  // Clusters and coordinate slots (x0, y0, x1, y1, x2, y2)
  localparam int NUM_CLUST   = 3;
  localparam int NUM_COORDS  = 2 * NUM_CLUST;
  localparam int SLOT_W      = 3;
  localparam int CLUST_W     = 2;

  // Register index codes of the configuration channel
  localparam int CFG_IDX_W   = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C0_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C0_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C1_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C1_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C2_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_C2_Y = 3'd5;

  // Stream widths, padded to whole bytes
  localparam int IN_RAW_W    = 2 * COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W   = CLUST_W + NUM_COORDS * CENT_W + NUM_CLUST * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DIST      = 6'b000010,
    S_PICK      = 6'b000100,
    S_DIV_START = 6'b001000,
    S_DIV_WAIT  = 6'b010000,
    S_EMIT      = 6'b100000
  } state_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/kmc_div.sv
`default_nettype none

module kmc_div
  import kmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [CNT_W-1:0]  rem;
  logic [DIVD_W-1:0] quot;
  logic [DIVC_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [CNT_W:0]    rem_sh;
  logic              fits;

  // Shift in the next dividend bit and trial-subtract
  assign rem_sh = {rem, quot[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, req.divisor};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quot <= req.dividend;
        cnt  <= DIVC_W'(DIVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= CNT_W'(rem_sh - {1'b0, req.divisor});
        end else begin
          rem <= rem_sh[CNT_W-1:0];
        end
        quot <= {quot[DIVD_W-2:0], fits};
        cnt  <= cnt - DIVC_W'(1);
        if (cnt == DIVC_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

FILE: rtl/kmeans_three_cluster_2d_top.sv
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: px, py; tuser: new_run; tlast: last_point
// m_*       out        m_tvalid / m_tready  tdata: cluster, centroids, sizes; tlast: pass_done
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data (seed registers)
//
// A point passes through S_IDLE to be accepted, S_DIST, in which one shared multiplier
// squares the six coordinate differences, S_PICK to pick the cluster, and S_EMIT
// to load the output register once it is free.
// A point with last_point then passes through S_DIV_START and S_DIV_WAIT: one shared
// restoring divider forms each centroid coordinate of a non-empty cluster, one bit a cycle.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register while the next point is accepted.
// Reset (rst, synchronous) clears seeds, centroids, sums and counts; config is
// always accepted.
`default_nettype none

module kmeans_three_cluster_2d_top
  import kmc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // px [8:0], py [17:9], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,
  // new_run [0]
  input  wire logic                   s_tuser,
  input  wire logic                   s_tlast,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // cluster [1:0], cent0_x [14:2], cent0_y [27:15], cent1_x [40:28],
  // cent1_y [53:41], cent2_x [66:54], cent2_y [79:67], size0 [90:80],
  // size1 [101:91], size2 [112:102], zero pad
  output logic [OUT_TDATA_W-1:0]      m_tdata,
  output logic                        m_tlast,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CENT_W-1:0]      cfg_data
);

  state_t                  state;
  logic [CENT_W-1:0]       seed     [NUM_COORDS];
  logic [CENT_W-1:0]       cent     [NUM_COORDS];
  logic [SUM_W-1:0]        coord_sum[NUM_COORDS];
  logic [CNT_W-1:0]        count    [NUM_CLUST];
  logic [CNT_W-1:0]        pass_total;
  logic [COORD_BITS-1:0]   pt_x;
  logic [COORD_BITS-1:0]   pt_y;
  logic                    pt_last;
  logic [SLOT_W-1:0]       step;
  logic [SLOT_W-1:0]       slot;
  logic [SQ_W-1:0]         prod;
  logic [DIST_W-1:0]       sq_dist  [NUM_CLUST];
  logic [CLUST_W-1:0]      pick;
  logic [CLUST_W-1:0]      clus;
  logic [CENT_W-1:0]       op_q;
  logic [CENT_W-1:0]       op_c;
  logic [CENT_W-1:0]       op_diff;
  logic [SLOT_W-1:0]       acc_slot;
  logic                    room;
  logic [OUT_RAW_W-1:0]    out_raw;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Select the coordinate pair for this multiplier step
  always_comb begin
    op_q = step[0] ? {pt_y, FRAC_BITS'(0)} : {pt_x, FRAC_BITS'(0)};
    op_c = (step < SLOT_W'(NUM_COORDS)) ? cent[step] : '0;
    op_diff = (op_q >= op_c) ? (op_q - op_c) : (op_c - op_q);
  end

  // Product of the previous step lands in this distance slot
  assign acc_slot = step - SLOT_W'(1);

  // Nearest centroid with the strict-less tie order
  always_comb begin
    if (sq_dist[0] < sq_dist[1]) begin
      pick = (sq_dist[0] < sq_dist[2]) ? CLUST_W'(0) : CLUST_W'(2);
    end else begin
      pick = (sq_dist[1] < sq_dist[2]) ? CLUST_W'(1) : CLUST_W'(2);
    end
  end

  assign room = pass_total < CNT_W'(MAX_POINTS);

  // Divider feed: current coordinate slot and its cluster count
  assign div_req.dividend = {coord_sum[slot], FRAC_BITS'(0)};
  assign div_req.divisor  = count[slot[SLOT_W-1:1]];
  assign div_req.start    = (state == S_DIV_START) && (count[slot[SLOT_W-1:1]] != '0);

  kmc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Pack the result item
  assign out_raw = {count[2], count[1], count[0],
                    cent[5], cent[4], cent[3], cent[2], cent[1], cent[0], clus};

  // Seed registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        seed[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          seed[i] <= cfg_data;
        end
      end
    end
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      pass_total <= '0;
      for (int i = 0; i < NUM_COORDS; i++) begin
        cent[i]      <= '0;
        coord_sum[i] <= '0;
      end
      for (int i = 0; i < NUM_CLUST; i++) begin
        count[i] <= '0;
      end
    end else begin
      // Drop the result once taken, unless a new one is loaded now
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            pt_x    <= s_tdata[COORD_BITS-1:0];
            pt_y    <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            pt_last <= s_tlast;
            step    <= '0;
            // Reload seeds and start a fresh pass
            if (s_tuser) begin
              for (int i = 0; i < NUM_COORDS; i++) begin
                cent[i]      <= seed[i];
                coord_sum[i] <= '0;
              end
              for (int i = 0; i < NUM_CLUST; i++) begin
                count[i] <= '0;
              end
              pass_total <= '0;
            end
            state <= S_DIST;
          end
        end
        S_DIST: begin
          // Square one difference, fold the previous square into its distance
          if (step < SLOT_W'(NUM_COORDS)) begin
            prod <= op_diff * op_diff;
          end
          if (step != '0) begin
            for (int i = 0; i < NUM_CLUST; i++) begin
              if (acc_slot[SLOT_W-1:1] == (SLOT_W-1)'(i)) begin
                sq_dist[i] <= acc_slot[0] ? (sq_dist[i] + DIST_W'(prod)) : DIST_W'(prod);
              end
            end
          end
          if (step == SLOT_W'(NUM_COORDS)) begin
            state <= S_PICK;
          end else begin
            step <= step + SLOT_W'(1);
          end
        end
        S_PICK: begin
          clus <= pick;
          // Accumulate while the pass has room
          if (room) begin
            for (int i = 0; i < NUM_CLUST; i++) begin
              if (pick == CLUST_W'(i)) begin
                coord_sum[2*i]   <= coord_sum[2*i] + SUM_W'(pt_x);
                coord_sum[2*i+1] <= coord_sum[2*i+1] + SUM_W'(pt_y);
                count[i]         <= count[i] + CNT_W'(1);
              end
            end
            pass_total <= pass_total + CNT_W'(1);
          end
          slot  <= '0;
          state <= pt_last ? S_DIV_START : S_EMIT;
        end
        S_DIV_START: begin
          // Skip coordinates of empty clusters
          if (div_req.start) begin
            state <= S_DIV_WAIT;
          end else if (slot == SLOT_W'(NUM_COORDS - 1)) begin
            state <= S_EMIT;
          end else begin
            slot <= slot + SLOT_W'(1);
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            cent[slot] <= div_rsp.quot[CENT_W-1:0];
            if (slot == SLOT_W'(NUM_COORDS - 1)) begin
              state <= S_EMIT;
            end else begin
              slot  <= slot + SLOT_W'(1);
              state <= S_DIV_START;
            end
          end
        end
        S_EMIT: begin
          // Hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_TDATA_W'(out_raw);
            m_tlast  <= pt_last;
            m_tvalid <= 1'b1;
            if (pt_last) begin
              for (int i = 0; i < NUM_COORDS; i++) begin
                coord_sum[i] <= '0;
              end
              for (int i = 0; i < NUM_CLUST; i++) begin
                count[i] <= '0;
              end
              pass_total <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Pass total never exceeds capacity
  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    pass_total <= CNT_W'(MAX_POINTS))
    else $error("pass total above capacity");

  // Cluster counts add up to the pass total
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (CNT_W+2)'(count[0]) + (CNT_W+2)'(count[1]) + (CNT_W+2)'(count[2])
      == (CNT_W+2)'(pass_total))
    else $error("cluster counts disagree with pass total");

  // Divider only runs on a non-empty cluster
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.divisor != '0))
    else $error("division by an empty cluster");

  // A free output register is loaded and the sequencer returns to idle
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!m_tvalid || m_tready)) |=> (state == S_IDLE && m_tvalid))
    else $error("result not loaded on emit");

  // Distance sequencing stays within its steps
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIST) |-> (step <= SLOT_W'(NUM_COORDS)))
    else $error("distance step out of range");

endmodule

`default_nettype wire

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kmc_pkg::*;

  localparam int RANDOM_POINTS   = 650;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 200;
  localparam int SIZE_BASE       = CLUST_W + NUM_COORDS * CENT_W;

  // Indexes past the six seed registers; the block drops these writes
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [CFG_IDX_W-1:0] SEED_REGS [NUM_COORDS] = '{
    CFG_SEED_C0_X, CFG_SEED_C0_Y, CFG_SEED_C1_X,
    CFG_SEED_C1_Y, CFG_SEED_C2_X, CFG_SEED_C2_Y
  };

  typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_LIGHT, RX_CLUMP} rx_mode_t;

  // One expected result: label, pass flag, centroids and pass sizes
  typedef struct packed {
    logic [CLUST_W-1:0]                cluster;
    logic                              pass_done;
    logic [NUM_COORDS-1:0][CENT_W-1:0] cent;
    logic [NUM_CLUST-1:0][CNT_W-1:0]   sizes;
  } label_t;

  // Tracks seeds, centroids and pass sums; predicts and checks each label
  class cluster_scoreboard;
    logic [CENT_W-1:0] seed [NUM_COORDS];
    logic [CENT_W-1:0] cent [NUM_COORDS];
    logic [SUM_W-1:0]  coord_total [NUM_COORDS];
    logic [CNT_W-1:0]  members [NUM_CLUST];
    int                filled;
    label_t            expected_labels [$];
    int                faults;
    int                checked;
    int                passes;
    int                overflowed;

    function new();
      for (int i = 0; i < NUM_COORDS; i++) begin
        seed[i] = '0;
        cent[i] = '0;
      end
      clear_pass();
      faults = 0;
      checked = 0;
      passes = 0;
      overflowed = 0;
    endfunction

    function void clear_pass();
      for (int i = 0; i < NUM_COORDS; i++) coord_total[i] = '0;
      for (int k = 0; k < NUM_CLUST; k++) members[k] = '0;
      filled = 0;
    endfunction

    function void load_seed(logic [CFG_IDX_W-1:0] idx, logic [CENT_W-1:0] val);
      if (idx < NUM_COORDS) seed[idx] = val;
    endfunction

    function int outstanding();
      return expected_labels.size();
    endfunction

    // Squared distance from the point, scaled to Q9.4, to centroid k
    function longint sq_gap(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py, int k);
      longint dx;
      longint dy;
      dx = (longint'(px) << FRAC_BITS) - longint'(cent[2 * k]);
      dy = (longint'(py) << FRAC_BITS) - longint'(cent[2 * k + 1]);
      return dx * dx + dy * dy;
    endfunction

    // Classify one point, fold it into the pass, queue the expected label
    function void assign_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                               logic fresh, logic closing);
      label_t want;
      longint gap [NUM_CLUST];
      longint quot;
      int     pick;
      if (fresh) begin
        for (int i = 0; i < NUM_COORDS; i++) cent[i] = seed[i];
        clear_pass();
      end
      for (int k = 0; k < NUM_CLUST; k++) gap[k] = sq_gap(px, py, k);
      // ties fall to the higher index
      if (gap[0] < gap[1]) pick = (gap[0] < gap[2]) ? 0 : 2;
      else pick = (gap[1] < gap[2]) ? 1 : 2;
      if (filled < MAX_POINTS) begin
        coord_total[2 * pick]     += SUM_W'(px);
        coord_total[2 * pick + 1] += SUM_W'(py);
        members[pick] += 1'b1;
        filled++;
      end else begin
        overflowed++;
      end
      want.cluster   = CLUST_W'(pick);
      want.pass_done = closing;
      for (int k = 0; k < NUM_CLUST; k++) want.sizes[k] = members[k];
      // end of pass: move non-empty centroids to their means
      if (closing) begin
        for (int k = 0; k < NUM_CLUST; k++) begin
          if (members[k] != 0) begin
            for (int a = 0; a < 2; a++) begin
              quot = (longint'(coord_total[2 * k + a]) << FRAC_BITS) / longint'(members[k]);
              cent[2 * k + a] = CENT_W'(quot);
            end
          end
        end
        clear_pass();
        passes++;
      end
      for (int i = 0; i < NUM_COORDS; i++) want.cent[i] = cent[i];
      expected_labels.push_back(want);
    endfunction

    function void fault(string what);
      faults++;
      if (faults <= 10) $display("MISMATCH at %0t: %s", $time, what);
    endfunction

    // Compare one accepted result with the oldest expected label
    function void match_label(logic [OUT_TDATA_W-1:0] data, logic done);
      label_t            want;
      logic [CENT_W-1:0] got_c;
      logic [CNT_W-1:0]  got_s;
      if (expected_labels.size() == 0) begin
        fault($sformatf("result with no point outstanding, tdata=%h", data));
        return;
      end
      want = expected_labels.pop_front();
      checked++;
      if (data[CLUST_W-1:0] !== want.cluster)
        fault($sformatf("result %0d cluster: expected %0d, got %0d",
                        checked, want.cluster, data[CLUST_W-1:0]));
      if (done !== want.pass_done)
        fault($sformatf("result %0d pass_done: expected %0b, got %0b",
                        checked, want.pass_done, done));
      for (int i = 0; i < NUM_COORDS; i++) begin
        got_c = data[CLUST_W + i * CENT_W +: CENT_W];
        if (got_c !== want.cent[i])
          fault($sformatf("result %0d cent%0d_%s: expected %0d, got %0d", checked,
                          i / 2, (i % 2) ? "y" : "x", want.cent[i], got_c));
      end
      for (int k = 0; k < NUM_CLUST; k++) begin
        got_s = data[SIZE_BASE + k * CNT_W +: CNT_W];
        if (got_s !== want.sizes[k])
          fault($sformatf("result %0d size%0d: expected %0d, got %0d",
                          checked, k, want.sizes[k], got_s));
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   s_tlast = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CENT_W-1:0]      cfg_data = '0;

  cluster_scoreboard board = new();

  int  burst_left = 8;
  int  gap_max = 4;
  int  steady_left = 0;
  bit  hold_off_req = 1'b0;
  int  holds_done = 0;
  int  cfg_writes = 0;

  kmeans_three_cluster_2d_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Check every result request taken at a rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.match_label(m_tdata, m_tlast);
  end

  // Receiver: change stall pattern every so often, honor long hold-offs
  initial begin : ready_pattern
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       stall_left;
    int       phase;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    stall_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        holds_done++;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 4));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:  m_tready <= 1'b1;
          RX_COIN:  m_tready <= 1'($urandom);
          RX_THIRD: m_tready <= (phase % 3 == 0);
          RX_LIGHT: m_tready <= ($urandom_range(0, 7) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
              stall_left = $urandom_range(1, 12);
              m_tready <= 1'b0;
            end else begin
              m_tready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Offer one point request; called at a falling edge, returns at one
  task automatic send_point(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
                            input logic fresh, input logic closing);
    s_tdata  <= IN_TDATA_W'({py, px});
    s_tuser  <= fresh;
    s_tlast  <= closing;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.assign_point(px, py, fresh, closing);
    @(negedge clk);
    // drop valid between bursts unless the sender must keep pushing
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        gap_max = $urandom_range(1, 14);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CENT_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.load_seed(idx, val);
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic program_seeds(input logic [CENT_W-1:0] c0x, input logic [CENT_W-1:0] c0y,
                               input logic [CENT_W-1:0] c1x, input logic [CENT_W-1:0] c1y,
                               input logic [CENT_W-1:0] c2x, input logic [CENT_W-1:0] c2y,
                               input bit spare);
    logic [CENT_W-1:0] plan [NUM_COORDS];
    plan[0] = c0x;
    plan[1] = c0y;
    plan[2] = c1x;
    plan[3] = c1y;
    plan[4] = c2x;
    plan[5] = c2y;
    if (spare) write_reg(CFG_SPARE_LO, CENT_W'($urandom));
    for (int i = 0; i < NUM_COORDS; i++) write_reg(SEED_REGS[i], plan[i]);
    if (spare) write_reg(CFG_SPARE_HI, CENT_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering points and wait until every label has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (board.outstanding() != 0);
  endtask

  // Coordinate near a hub, at an extreme, or anywhere
  function automatic logic [COORD_BITS-1:0] pick_coord(int hub);
    int v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return COORD_BITS'($urandom);
      default: begin
        v = hub + int'($urandom_range(0, 80)) - 40;
        if (v < 0) v = 0;
        if (v > (1 << COORD_BITS) - 1) v = (1 << COORD_BITS) - 1;
        return COORD_BITS'(v);
      end
    endcase
  endfunction

  function automatic logic [CENT_W-1:0] pick_seed(int hub);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return CENT_W'($urandom);
      default: return CENT_W'((hub << FRAC_BITS) + $urandom_range(0, (1 << FRAC_BITS) - 1));
    endcase
  endfunction

  initial begin : stimulus
    int   sent;
    int   runs;
    int   pass_cnt;
    int   len;
    int   blob;
    logic fresh;
    logic closing;
    int   hub [NUM_COORDS];
    sent = 0;
    runs = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Centroids still zero after reset: all three tie
    send_point(9'd0, 9'd0, 1'b0, 1'b0);
    send_point(9'd511, 9'd511, 1'b0, 1'b1);

    // Corner seeds, spare indexes written too
    settle();
    program_seeds(13'd0, 13'd0, 13'd8191, 13'd8191, 13'd8176, 13'd0, 1'b1);
    send_point(9'd0, 9'd0, 1'b1, 1'b0);
    send_point(9'd511, 9'd511, 1'b0, 1'b0);
    send_point(9'd511, 9'd0, 1'b0, 1'b0);
    send_point(9'd0, 9'd511, 1'b0, 1'b1);
    // both flags on one point
    send_point(9'd256, 9'd256, 1'b1, 1'b1);
    send_point(9'd100, 9'd200, 1'b0, 1'b0);
    send_point(9'd300, 9'd17, 1'b0, 1'b1);

    // Centroids 0 and 1 coincide
    settle();
    program_seeds(13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd0, 13'd0, 1'b0);
    send_point(9'd511, 9'd511, 1'b1, 1'b0);
    send_point(9'd0, 9'd0, 1'b0, 1'b0);
    send_point(9'd170, 9'd341, 1'b0, 1'b1);

    // All seeds at the top of the range
    settle();
    program_seeds(13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'd8191, 1'b0);
    send_point(9'd511, 9'd511, 1'b1, 1'b1);
    send_point(9'd0, 9'd0, 1'b0, 1'b1);

    // Centroids 0 and 2 coincide
    settle();
    program_seeds(13'd0, 13'd0, 13'd8191, 13'd8191, 13'd0, 13'd0, 1'b0);
    send_point(9'd0, 9'd0, 1'b1, 1'b0);
    send_point(9'd5, 9'd9, 1'b0, 1'b1);

    // Random runs of passes around random hubs, with some broken flags
    while (sent < RANDOM_POINTS) begin
      for (int c = 0; c < NUM_COORDS; c++) hub[c] = $urandom_range(0, (1 << COORD_BITS) - 1);
      if (runs % 5 == 0) begin
        settle();
        program_seeds(pick_seed(hub[0]), pick_seed(hub[1]), pick_seed(hub[2]),
                      pick_seed(hub[3]), pick_seed(hub[4]), pick_seed(hub[5]),
                      $urandom_range(0, 2) == 0);
      end
      // hold the output off while the sender keeps pushing
      if (runs % 12 == 3) begin
        hold_off_req = 1'b1;
        steady_left = 12;
      end
      pass_cnt = $urandom_range(1, 4);
      for (int p = 0; p < pass_cnt; p++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
          blob = $urandom_range(0, NUM_CLUST - 1);
          fresh = (p == 0 && i == 0 && $urandom_range(0, 7) != 0);
          closing = (i == len - 1);
          if ($urandom_range(0, 24) == 0) begin
            fresh = 1'($urandom);
            closing = 1'($urandom);
          end
          send_point(pick_coord(hub[2 * blob]), pick_coord(hub[2 * blob + 1]), fresh, closing);
          sent++;
        end
      end
      runs++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d points in %0d finished passes; %0d arrived with the pass full.",
             board.checked, board.passes, board.overflowed);
    $display("Seed and spare registers written %0d times; output held off %0d times.",
             cfg_writes, holds_done);
    if (board.faults == 0 && board.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total", board.faults);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20ms;
    $display("Timed out with %0d labels outstanding", board.outstanding());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: kmeans_three_cluster_2d_top.f
rtl/kmc_pkg.sv
rtl/kmc_div.sv
rtl/kmeans_three_cluster_2d_top.sv
dv/tb.sv
